FILE: rtl/core/eps_pkg.sv
// Shared types and constants for the EEPROM page splitter.
package eps_pkg;

    localparam int ADDR_W = 12;
    localparam int LEN_W  = 9;
    localparam int CNT_W  = 6;

    localparam logic [ADDR_W-1:0] START_LIMIT = 12'd1024;
    localparam int                MAX_CHUNKS  = 64;
    localparam logic [7:0]        BASE_RESET  = 8'd160;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_BAD_ADDR = 2'd1;
    localparam status_t STATUS_RANGE   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] left_next;
        logic              last;
    } chunk_t;

endpackage

FILE: rtl/core/eeprom_page_split.sv
// Top level: EEPROM request checker and page-boundary chunk splitter.
// The request is registered into the working registers, then each result into the output registers.
// Throughput: one result per cycle while out_stall is low; in_stall stays high from
//   acceptance of a request until its last result is loaded (a status-only result is single).
// The chunk unit computes one chunk per cycle while out_stall is low; at most 64 chunks per request.
// Reset (rst_n low, asynchronous): idle, no result pending, device_base = 0xA0.
module eeprom_page_split #(
    parameter int PAGE_BYTES   = 16,
    parameter int MEMORY_BYTES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [7:0]                 device_base,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic [eps_pkg::ADDR_W-1:0] start_address,
    input  logic [eps_pkg::ADDR_W-1:0] byte_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       kind_out,
    output logic [1:0]                 status,
    output logic [7:0]                 chunk_dev,
    output logic [7:0]                 chunk_word,
    output logic [eps_pkg::LEN_W-1:0]  chunk_length,
    output logic [eps_pkg::ADDR_W-1:0] buffer_offset,
    output logic                       last
);

    localparam int SUM_W = eps_pkg::ADDR_W + 1;

    eps_pkg::state_t            state_reg, state_next;
    logic [7:0]                 base_reg, base_next;
    logic                       kind_reg, kind_next;
    eps_pkg::status_t           stat_reg, stat_next;
    logic [eps_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [eps_pkg::ADDR_W-1:0] left_reg, left_next;
    logic [eps_pkg::ADDR_W-1:0] off_reg, off_next;
    logic [eps_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic                       ov_reg, ov_next;
    logic                       okind_reg, okind_next;
    eps_pkg::status_t           ostat_reg, ostat_next;
    logic [7:0]                 odev_reg, odev_next;
    logic [7:0]                 oword_reg, oword_next;
    logic [eps_pkg::LEN_W-1:0]  olen_reg, olen_next;
    logic [eps_pkg::ADDR_W-1:0] ooff_reg, ooff_next;
    logic                       olast_reg, olast_next;

    eps_pkg::chunk_t            chunk;
    logic [SUM_W-1:0]           end_sum;
    logic                       load;

    eps_chunk_unit #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_chunk (
        .addr (addr_reg),
        .left (left_reg),
        .cnt  (cnt_reg),
        .chunk(chunk)
    );

    assign cfg_ready      = 1'b1;
    assign in_stall       = (state_reg != eps_pkg::ST_IDLE);
    assign out_valid      = ov_reg;
    assign kind_out       = okind_reg;
    assign status         = ostat_reg;
    assign chunk_dev      = odev_reg;
    assign chunk_word     = oword_reg;
    assign chunk_length   = olen_reg;
    assign buffer_offset  = ooff_reg;
    assign last           = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eps_pkg::ST_IDLE;
            base_reg  <= eps_pkg::BASE_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        stat_reg  <= stat_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        off_reg   <= off_next;
        cnt_reg   <= cnt_next;
        okind_reg <= okind_next;
        ostat_reg <= ostat_next;
        odev_reg  <= odev_next;
        oword_reg <= oword_next;
        olen_reg  <= olen_next;
        ooff_reg  <= ooff_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        kind_next  = kind_reg;
        stat_next  = stat_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        okind_next = okind_reg;
        ostat_next = ostat_reg;
        odev_next  = odev_reg;
        oword_next = oword_reg;
        olen_next  = olen_reg;
        ooff_next  = ooff_reg;
        olast_next = olast_reg;
        end_sum    = SUM_W'(start_address) + SUM_W'(byte_count);
        load       = !ov_reg || !out_stall;

        if (cfg_valid && cfg_ready)
            base_next = device_base;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            eps_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    kind_next = kind;
                    addr_next = start_address;
                    left_next = byte_count;
                    off_next  = '0;
                    cnt_next  = '0;
                    priority if (start_address > eps_pkg::START_LIMIT)
                        stat_next = eps_pkg::STATUS_BAD_ADDR;
                    else if (end_sum > SUM_W'(MEMORY_BYTES))
                        stat_next = eps_pkg::STATUS_RANGE;
                    else
                        stat_next = eps_pkg::STATUS_OK;
                    state_next = eps_pkg::ST_EMIT;
                end
            end
            eps_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    ov_next    = 1'b1;
                    okind_next = kind_reg;
                    ostat_next = stat_reg;
                    if (stat_reg != eps_pkg::STATUS_OK || left_reg == '0)
                    begin
                        odev_next  = '0;
                        oword_next = '0;
                        olen_next  = '0;
                        ooff_next  = '0;
                        olast_next = 1'b1;
                        state_next = eps_pkg::ST_IDLE;
                    end
                    else
                    begin
                        odev_next  = base_reg | {3'b000, addr_reg[11:8], 1'b0};
                        oword_next = addr_reg[7:0];
                        olen_next  = chunk.len;
                        ooff_next  = off_reg;
                        olast_next = chunk.last;
                        addr_next  = addr_reg + eps_pkg::ADDR_W'(chunk.len);
                        off_next   = off_reg + eps_pkg::ADDR_W'(chunk.len);
                        left_next  = chunk.left_next;
                        cnt_next   = cnt_reg + eps_pkg::CNT_W'(1);
                        if (chunk.last)
                            state_next = eps_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = eps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/eps_chunk_unit.sv
// Chunk length unit: page room, clipped length, remaining bytes, last flag.
module eps_chunk_unit #(
    parameter int PAGE_BYTES = 16
) (
    input  logic [eps_pkg::ADDR_W-1:0] addr,
    input  logic [eps_pkg::ADDR_W-1:0] left,
    input  logic [eps_pkg::CNT_W-1:0]  cnt,
    output eps_pkg::chunk_t            chunk
);

    localparam int OFS_W  = $clog2(PAGE_BYTES);
    localparam int ROOM_W = OFS_W + 1;

    logic [ROOM_W-1:0]          room;
    logic [eps_pkg::ADDR_W-1:0] room_ext;
    logic [eps_pkg::ADDR_W-1:0] len_ext;

    always_comb
    begin
        room     = ROOM_W'(PAGE_BYTES) - ROOM_W'(addr[OFS_W-1:0]);
        room_ext = eps_pkg::ADDR_W'(room);
        len_ext  = (left < room_ext) ? left : room_ext;
        chunk.len       = eps_pkg::LEN_W'(len_ext);
        chunk.left_next = left - len_ext;
        chunk.last      = (chunk.left_next == '0) ||
                          (cnt == eps_pkg::CNT_W'(eps_pkg::MAX_CHUNKS - 1));
    end

endmodule

FILE: rtl/core/eeprom_page_split_chk.sv
// Port-level checker for the EEPROM page splitter, bound to the top level.
module eeprom_page_split_chk #(
    parameter int PAGE_BYTES = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       kind_out,
    input logic [1:0]                 status,
    input logic [7:0]                 chunk_dev,
    input logic [7:0]                 chunk_word,
    input logic [eps_pkg::LEN_W-1:0]  chunk_length,
    input logic [eps_pkg::ADDR_W-1:0] buffer_offset,
    input logic                       last
);

    localparam int OFS_W = $clog2(PAGE_BYTES);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind_out) && $stable(status) &&
        $stable(chunk_dev) && $stable(chunk_word) && $stable(chunk_length) &&
        $stable(buffer_offset) && $stable(last))
        else $error("stalled result changed");

    // error results are single and empty
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != eps_pkg::STATUS_OK |->
        last && chunk_length == '0 && buffer_offset == '0)
        else $error("error result not final or not empty");

    // a chunk never crosses a page
    a_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_length != '0 |->
        (10'(chunk_word[OFS_W-1:0]) + 10'(chunk_length)) <= 10'(PAGE_BYTES))
        else $error("chunk crosses page boundary");

    // request still in progress until its last result
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("new request taken before last result");

endmodule

bind eeprom_page_split eeprom_page_split_chk #(.PAGE_BYTES(PAGE_BYTES)) u_chk (.*);
